@@ rtl/qau_pkg.sv @@
// Shared types and constants for the quaternion arithmetic unit.
// No dependencies.
package qau_pkg;

  localparam int FRAC_BITS = 16;

  localparam int SW   = 66;              // sum of four 64-bit products
  localparam int QW   = 34;              // quotient bits kept, upper bits checked for overflow
  localparam int WW   = SW + QW;         // divider remainder width
  localparam int NSTG = 6 + QW;          // pipeline stages, output register included

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // One slot of the divider pipeline; non-divide results ride along in alt.
  typedef struct packed {
    op_t                  kind;
    logic [3:0][31:0]     alt;
    logic                 alt_ovf;
    logic [3:0][WW-1:0]   rem;
    logic [WW-1:0]        ds;
    logic [3:0][QW-1:0]   q;
    logic [3:0]           neg;
    logic                 dbz;
  } div_st_t;

endpackage

@@ rtl/qau_div_step.sv @@
// One restoring-division step for four lanes, registered.
// Depends on qau_pkg.
module qau_div_step import qau_pkg::*; (
  input  logic    clk,
  input  logic    load,
  input  div_st_t d_in,
  output div_st_t st_r
);

  div_st_t st_nxt;

  always_comb begin
    st_nxt = d_in;
    for (int l = 0; l < 4; l++) begin
      if (d_in.rem[l] >= d_in.ds) begin
        st_nxt.rem[l] = d_in.rem[l] - d_in.ds;
        st_nxt.q[l]   = {d_in.q[l][QW-2:0], 1'b1};
      end else begin
        st_nxt.q[l]   = {d_in.q[l][QW-2:0], 1'b0};
      end
    end
    st_nxt.ds = d_in.ds >> 1;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      st_r <= st_nxt;
    end
  end

endmodule

@@ rtl/quaternion_arith_unit.sv @@
// Quaternion add / subtract / Hamilton multiply / divide, Q16.16, pipelined.
// Depends on qau_pkg and qau_div_step.
//
// Input beat: in_tuser carries the operation (add, subtract, multiply,
// divide), in_tdata the two operand quaternions x and y. Output beat:
// out_tdata holds the result quaternion, out_tuser the overflow and
// divide-by-zero flags. Every input beat gives exactly one output beat.
//
// Every operation passes through the same stages. Throughput: one beat
// per cycle while out_tready is high. The depth is
// set by the divider: one restoring step per stage for 34 quotient bits,
// four lanes side by side, after product, sum, rounding and setup stages.
// Multiplies use 20 signed 32x32 multipliers in one stage.
//
// Every stage has a valid bit. A stage takes new data when it is empty or
// when the stage after it moves, so bubbles close up and a stalled receiver
// fills the pipeline before in_tready drops. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are
// not reset.
module quaternion_arith_unit import qau_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // x_real, x_i, x_j, x_k, y_real, y_i, y_j, y_k (32 bits each, from bit 0)
  input  logic [255:0] in_tdata,
  // kind
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // r_real, r_i, r_j, r_k (32 bits each, from bit 0)
  output logic [127:0] out_tdata,
  // overflow, divide_by_zero
  output logic [1:0]   out_tuser
);

  localparam logic [SW-1:0] HALF_LSB =
    (FRAC_BITS == 0) ? '0 : (SW'(1) << (FRAC_BITS - 1));

  // ---------------- flow control ----------------
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_tready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_tvalid;
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // ---------------- stage 0: input register ----------------
  op_t               op0_r;
  logic signed [31:0] x0_r [4];
  logic signed [31:0] y0_r [4];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      op0_r <= op_t'(in_tuser);
      for (int l = 0; l < 4; l++) begin
        x0_r[l] <= in_tdata[32*l +: 32];
        y0_r[l] <= in_tdata[128 + 32*l +: 32];
      end
    end
  end

  // ---------------- stage 1: products, add/sub ----------------
  op_t                op1_r;
  logic signed [63:0] p1_r  [16];   // x[i]*y[j] at 4*i+j
  logic        [62:0] sq1_r [4];
  logic signed [32:0] as1_r [4];
  logic signed [63:0] sqp   [4];

  always_comb begin
    for (int l = 0; l < 4; l++) sqp[l] = y0_r[l] * y0_r[l];
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      op1_r <= op0_r;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) p1_r[4*i+j] <= x0_r[i] * y0_r[j];
        sq1_r[i] <= sqp[i][62:0];
        if (op0_r == OP_SUB) as1_r[i] <= 33'(x0_r[i]) - 33'(y0_r[i]);
        else                 as1_r[i] <= 33'(x0_r[i]) + 33'(y0_r[i]);
      end
    end
  end

  // ---------------- stage 2: sums of products ----------------
  op_t                 op2_r;
  logic signed [SW-1:0] ms2_r [4];
  logic        [64:0]   den2_r;
  logic signed [32:0]   as2_r [4];
  logic signed [SW-1:0] pe    [16];
  logic signed [SW-1:0] ms_nxt [4];

  always_comb begin
    for (int k = 0; k < 16; k++) pe[k] = SW'(p1_r[k]);
    if (op1_r == OP_MUL) begin
      ms_nxt[0] = pe[0]  - pe[5]  - pe[10] - pe[15];
      ms_nxt[1] = pe[1]  + pe[4]  + pe[11] - pe[14];
      ms_nxt[2] = pe[2]  - pe[7]  + pe[8]  + pe[13];
      ms_nxt[3] = pe[3]  + pe[6]  - pe[9]  + pe[12];
    end else begin
      ms_nxt[0] = pe[0]  + pe[5]  + pe[10] + pe[15];
      ms_nxt[1] = pe[4]  - pe[1]  - pe[14] + pe[11];
      ms_nxt[2] = pe[8]  + pe[13] - pe[2]  - pe[7];
      ms_nxt[3] = pe[12] - pe[9]  + pe[6]  - pe[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      op2_r  <= op1_r;
      den2_r <= 65'(sq1_r[0]) + 65'(sq1_r[1]) + 65'(sq1_r[2]) + 65'(sq1_r[3]);
      for (int l = 0; l < 4; l++) begin
        ms2_r[l] <= ms_nxt[l];
        as2_r[l] <= as1_r[l];
      end
    end
  end

  // ---------------- stage 3: round/saturate, divide operands ----------------
  op_t              op3_r;
  logic [3:0][31:0] alt3_r;
  logic             altovf3_r;
  logic [SW-1:0]    mag3_r [4];
  logic [3:0]       neg3_r;
  logic [64:0]      den3_r;
  logic             dbz3_r;
  logic [3:0][31:0] alt_nxt;
  logic [3:0]       lane_ovf;
  logic signed [SW-1:0] rnd [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      rnd[l] = (ms2_r[l] + $signed(HALF_LSB)) >>> FRAC_BITS;
      if (op2_r == OP_MUL) begin
        lane_ovf[l] = (rnd[l][SW-1:31] != '0) && (rnd[l][SW-1:31] != '1);
        if (!lane_ovf[l])       alt_nxt[l] = rnd[l][31:0];
        else if (rnd[l][SW-1])  alt_nxt[l] = 32'h8000_0000;
        else                    alt_nxt[l] = 32'h7FFF_FFFF;
      end else begin
        lane_ovf[l] = as2_r[l][32] != as2_r[l][31];
        if (!lane_ovf[l])       alt_nxt[l] = as2_r[l][31:0];
        else if (as2_r[l][32])  alt_nxt[l] = 32'h8000_0000;
        else                    alt_nxt[l] = 32'h7FFF_FFFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      op3_r     <= op2_r;
      alt3_r    <= alt_nxt;
      altovf3_r <= |lane_ovf;
      den3_r    <= den2_r;
      dbz3_r    <= (op2_r == OP_DIV) && (den2_r == '0);
      for (int l = 0; l < 4; l++) begin
        neg3_r[l] <= ms2_r[l][SW-1];
        mag3_r[l] <= ms2_r[l][SW-1] ? SW'(-ms2_r[l]) : ms2_r[l];
      end
    end
  end

  // ---------------- stage 4: divider setup ----------------
  // quotient = (|n| * 2^(F+1) + den) / (2*den); first step compares with 2*den << 33
  div_st_t st4_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      st4_r.kind    <= op3_r;
      st4_r.alt     <= alt3_r;
      st4_r.alt_ovf <= altovf3_r;
      st4_r.neg     <= neg3_r;
      st4_r.dbz     <= dbz3_r;
      st4_r.ds      <= WW'(den3_r) << QW;
      for (int l = 0; l < 4; l++) begin
        st4_r.rem[l] <= (WW'(mag3_r[l]) << (FRAC_BITS + 1)) + WW'(den3_r);
        st4_r.q[l]   <= '0;
      end
    end
  end

  // ---------------- stages 5..: one quotient bit per stage ----------------
  div_st_t st_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    if (k == 0) begin : g_first
      qau_div_step u_step (
        .clk  (clk),
        .load (adv[5+k]),
        .d_in (st4_r),
        .st_r (st_r[k])
      );
    end else begin : g_next
      qau_div_step u_step (
        .clk  (clk),
        .load (adv[5+k]),
        .d_in (st_r[k-1]),
        .st_r (st_r[k])
      );
    end
  end

  // ---------------- output register ----------------
  div_st_t          fin;
  logic [3:0][31:0] res_nxt;
  logic [3:0]       qovf;
  logic [127:0]     data_r;
  logic [1:0]       flag_r;

  assign fin = st_r[QW-1];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (fin.neg[l]) begin
        qovf[l] = (fin.q[l][QW-1:32] != '0) || (fin.q[l][31] && (fin.q[l][30:0] != '0));
        res_nxt[l] = qovf[l] ? 32'h8000_0000 : 32'(-fin.q[l]);
      end else begin
        qovf[l] = fin.q[l][QW-1:31] != '0;
        res_nxt[l] = qovf[l] ? 32'h7FFF_FFFF : fin.q[l][31:0];
      end
      if (fin.dbz) begin
        qovf[l]    = 1'b0;
        res_nxt[l] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NSTG-1]) begin
      if (fin.kind == OP_DIV) begin
        data_r <= res_nxt;
        flag_r <= {fin.dbz, |qovf};
      end else begin
        data_r <= fin.alt;
        flag_r <= {1'b0, fin.alt_ovf};
      end
    end
  end

  assign out_tvalid = v_r[NSTG-1];
  assign out_tdata  = data_r;
  assign out_tuser  = flag_r;

endmodule
